FILE: rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and constants for the palette rotation timer.
// ----------------------------------------------------------------------------
package prt_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned SLOT_W      = 24;

   localparam logic [7:0]  SLOT_OFF     = 8'hFF;
   localparam logic [11:0] TICK_UNIT_MS = 12'd10;
   localparam logic [11:0] MAX_WAIT_MS  = 12'd2550;   // 255 * 10 ms

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;   // unused: no change, all-zero result

   // outcome of evaluating one rotation slot on a tick
   typedef struct packed {
      logic        update;     // enabled and due: rearm deadline
      logic        rotate;     // enabled, due and clipped range holds two or more entries
      logic [8:0]  len;        // clipped range length
      logic [31:0] deadline;   // rearmed deadline
      logic [11:0] best;       // running minimum distance after this slot
   } slot_eval_type;

endpackage

FILE: rtl/palette_rotation_timer.sv
// ----------------------------------------------------------------------------
// palette_rotation_timer
// Color-cycling engine: palette RAM plus rotation slots that turn ranges of
// entries one place toward the lower index on millisecond ticks.
// ----------------------------------------------------------------------------
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid/req_stall, mode, now, idx, rgb | in
//   rsp     | rsp_valid/rsp_stall, due, color, rotated | out
//   csr     | csr_wr_en, csr_index, csr_wdata          | in
//
// During a tick, every slot that rotates a range of len entries moves them
//   through the single port pair of the palette RAM, one entry per cycle.
// One item in flight; req_stall is high from accept until the result is
//   handed to the output register, which may still hold the prior item.
// Reset (synchronous) turns all slots off and clears all deadlines;
//   palette contents are undefined until written. No clearing pass.
// rsp_stall only holds the output register and the final state.
// ----------------------------------------------------------------------------
module palette_rotation_timer import prt_pkg::*; #(
   parameter int PALETTE_DEPTH = 64,
   parameter int SLOT_COUNT    = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_mode,
   input  logic [31:0]            req_now_ms,
   input  logic [5:0]             req_entry_index,
   input  logic [23:0]            req_entry_color,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_next_due_ms,
   output logic [23:0]            rsp_read_color,
   output logic                   rsp_rotated,
   // register write port
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SLOT_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(PALETTE_DEPTH);
   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAL_READ,
      S_SLOT,
      S_ROT_SAVE,
      S_ROT_MOVE,
      S_ROT_LAST,
      S_DONE
   } state_type;

   // control
   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] slot_cfg_ff [SLOT_COUNT];
   logic [SLOT_W-1:0] slot_cfg_in [SLOT_COUNT];
   logic [31:0]       deadline_ff [SLOT_COUNT];
   logic [31:0]       deadline_in [SLOT_COUNT];

   // working payload
   logic [SW-1:0]     slot_ff, slot_in;
   logic [31:0]       now_ff, now_in;
   logic [11:0]       best_ff, best_in;
   logic              is_tick_ff, is_tick_in;
   logic              rotated_ff, rotated_in;
   logic [23:0]       color_ff, color_in;
   logic [23:0]       saved_ff, saved_in;
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [7:0]        remain_ff, remain_in;

   // output register
   logic [31:0]       rsp_due_ff, rsp_due_in;
   logic [23:0]       rsp_color_ff, rsp_color_in;
   logic              rsp_rot_ff, rsp_rot_in;

   // palette RAM port
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [23:0]       ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [23:0]       ram_rdata;

   logic              req_accept;
   logic              out_free;
   logic              csr_hit;
   logic [8:0]        req_idx_wide;
   logic              req_idx_ok;
   logic [8:0]        len_minus1;
   logic              last_slot;
   logic [SLOT_W-1:0] cur_cfg;
   slot_eval_type     eval;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_due_ms = rsp_due_ff;
   assign rsp_read_color  = rsp_color_ff;
   assign rsp_rotated     = rsp_rot_ff;

   // writes to indexes past the last slot are dropped
   assign csr_hit = csr_wr_en && ({1'b0, csr_index} < (CSR_INDEX_W + 1)'(SLOT_COUNT));

   assign req_idx_wide = 9'(req_entry_index);
   assign req_idx_ok   = (req_idx_wide < 9'(PALETTE_DEPTH));

   assign cur_cfg    = slot_cfg_ff[slot_ff];
   assign last_slot  = (slot_ff == SW'(SLOT_COUNT - 1));
   assign len_minus1 = eval.len - 9'd1;

   prt_slot_eval #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_slot_eval (
      .slot_cfg (cur_cfg),
      .deadline (deadline_ff[slot_ff]),
      .now_ms   (now_ff),
      .best_in  (best_ff),
      .eval     (eval)
   );

   prt_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      slot_cfg_in  = slot_cfg_ff;
      deadline_in  = deadline_ff;
      slot_in      = slot_ff;
      now_in       = now_ff;
      best_in      = best_ff;
      is_tick_in   = is_tick_ff;
      rotated_in   = rotated_ff;
      color_in     = color_ff;
      saved_in     = saved_ff;
      wr_ptr_in    = wr_ptr_ff;
      remain_in    = remain_ff;
      rsp_due_in   = rsp_due_ff;
      rsp_color_in = rsp_color_ff;
      rsp_rot_in   = rsp_rot_ff;
      ram_we       = 1'b0;
      ram_waddr    = wr_ptr_ff;
      ram_wdata    = ram_rdata;
      ram_raddr    = wr_ptr_ff;

      if (csr_hit) begin
         slot_cfg_in[csr_index[SW-1:0]] = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               now_in     = req_now_ms;
               best_in    = MAX_WAIT_MS;
               slot_in    = '0;
               rotated_in = 1'b0;
               color_in   = 24'd0;
               is_tick_in = (req_mode == MODE_TICK);
               state_in   = S_DONE;
               case (req_mode)
                  MODE_TICK: begin
                     state_in = S_SLOT;
                  end
                  MODE_WRITE: begin
                     ram_we    = req_idx_ok;
                     ram_waddr = req_idx_wide[AW-1:0];
                     ram_wdata = req_entry_color;
                  end
                  MODE_READ: begin
                     ram_raddr = req_idx_wide[AW-1:0];
                     if (req_idx_ok) begin
                        state_in = S_PAL_READ;
                     end
                  end
                  default: begin
                     // unused mode: no change, all-zero result
                  end
               endcase
            end
         end

         S_PAL_READ: begin
            color_in = ram_rdata;
            state_in = S_DONE;
         end

         S_SLOT: begin
            best_in = eval.best;
            if (eval.update) begin
               deadline_in[slot_ff] = eval.deadline;
            end
            if (eval.rotate) begin
               // fetch the first entry; it wraps to the end of the range
               ram_raddr  = cur_cfg[AW-1:0];
               wr_ptr_in  = cur_cfg[AW-1:0];
               remain_in  = len_minus1[7:0];
               rotated_in = 1'b1;
               state_in   = S_ROT_SAVE;
            end else if (last_slot) begin
               state_in = S_DONE;
            end else begin
               slot_in = slot_ff + SW'(1);
            end
         end

         S_ROT_SAVE: begin
            saved_in  = ram_rdata;
            ram_raddr = wr_ptr_ff + AW'(1);
            state_in  = S_ROT_MOVE;
         end

         S_ROT_MOVE: begin
            // entry k+1 arrives, lands at k; next read runs one ahead
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_ff;
            ram_wdata = ram_rdata;
            ram_raddr = wr_ptr_ff + AW'(2);
            wr_ptr_in = wr_ptr_ff + AW'(1);
            remain_in = remain_ff - 8'd1;
            if (remain_ff == 8'd1) begin
               state_in = S_ROT_LAST;
            end
         end

         S_ROT_LAST: begin
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_ff;
            ram_wdata = saved_ff;
            if (last_slot) begin
               state_in = S_DONE;
            end else begin
               slot_in  = slot_ff + SW'(1);
               state_in = S_SLOT;
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_due_in   = is_tick_ff ? (now_ff + {20'd0, best_ff}) : 32'd0;
               rsp_color_in = color_ff;
               rsp_rot_in   = rotated_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_cfg_ff[i] <= SLOT_W'(SLOT_OFF);
            deadline_ff[i] <= 32'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_cfg_ff  <= slot_cfg_in;
         deadline_ff  <= deadline_in;
         slot_ff      <= slot_in;
         now_ff       <= now_in;
         best_ff      <= best_in;
         is_tick_ff   <= is_tick_in;
         rotated_ff   <= rotated_in;
         color_ff     <= color_in;
         saved_ff     <= saved_in;
         wr_ptr_ff    <= wr_ptr_in;
         remain_ff    <= remain_in;
         rsp_due_ff   <= rsp_due_in;
         rsp_color_ff <= rsp_color_in;
         rsp_rot_ff   <= rsp_rot_in;
      end
   end

endmodule

FILE: rtl/prt_ram.sv
// ----------------------------------------------------------------------------
// prt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module prt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/prt_slot_eval.sv
// ----------------------------------------------------------------------------
// prt_slot_eval
// Evaluates one rotation slot against the tick time: due test, range
// clipping, rearm value and running minimum distance.
// ----------------------------------------------------------------------------
module prt_slot_eval import prt_pkg::*; #(
   parameter int PALETTE_DEPTH = 64
) (
   input  logic [SLOT_W-1:0] slot_cfg,
   input  logic [31:0]       deadline,
   input  logic [31:0]       now_ms,
   input  logic [11:0]       best_in,
   output slot_eval_type     eval
);

   logic [7:0]  first;
   logic [7:0]  count;
   logic [7:0]  period;
   logic        enabled;
   logic        due;
   logic        in_palette;
   logic [8:0]  avail;
   logic [8:0]  len;
   logic [11:0] rearm;
   logic [31:0] distance;

   assign first  = slot_cfg[7:0];
   assign count  = slot_cfg[15:8];
   assign period = slot_cfg[23:16];

   assign enabled    = (first != SLOT_OFF);
   assign due        = (now_ms >= deadline);
   assign in_palette = ({1'b0, first} < 9'(PALETTE_DEPTH));
   assign avail      = 9'(PALETTE_DEPTH) - {1'b0, first};

   always_comb begin
      if (!in_palette) begin
         len = 9'd0;
      end else if ({1'b0, count} < avail) begin
         len = {1'b0, count};
      end else begin
         len = avail;
      end
   end

   assign rearm    = {4'd0, period} * TICK_UNIT_MS;
   assign distance = due ? {20'd0, rearm} : (deadline - now_ms);

   always_comb begin
      eval.update   = enabled && due;
      eval.rotate   = enabled && due && (len >= 9'd2);
      eval.len      = len;
      eval.deadline = now_ms + {20'd0, rearm};
      eval.best     = (enabled && (distance < {20'd0, best_in})) ? distance[11:0] : best_in;
   end

endmodule

FILE: rtl/prt_checker.sv
// ----------------------------------------------------------------------------
// prt_checker
// Port-level checks for the palette rotation timer, bound to the top level.
// ----------------------------------------------------------------------------
module prt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_next_due_ms,
   input logic [23:0] rsp_read_color,
   input logic        rsp_rotated
);

   // a stalled result item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // every accepted item makes the block busy in the cycle after it is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken without going busy");

   // a rotating tick never carries read data
   a_rotate_no_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rotated |-> rsp_read_color == 24'd0)
      else $error("rotated tick with read color");

   // read data only comes with a zero deadline
   a_color_no_due: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_color != 24'd0) |-> rsp_next_due_ms == 32'd0)
      else $error("read item with deadline");

endmodule

bind palette_rotation_timer prt_checker u_prt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_next_due_ms (rsp_next_due_ms),
   .rsp_read_color  (rsp_read_color),
   .rsp_rotated     (rsp_rotated)
);
